### rtl/rpmo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpmo_pkg
// Types, constants and the per-stage step function of the RNS pointwise
// modular multiply/add core.
// ----------------------------------------------------------------------------
package rpmo_pkg;

	localparam int CW = 62;               // coefficient and modulus width
	localparam int AW = 64;               // working width of a lane accumulator
	localparam int MOD_REGS = 4;          // number of modulus registers
	localparam int IDX_W = 2;             // register and tower index width
	localparam int RED_STEPS = CW;        // one operand bit per stage for a mod q
	localparam int MUL_STEPS = 2 * CW;    // doubling and conditional add per bit
	localparam int STEPS = RED_STEPS + MUL_STEPS;
	localparam int BIT_W = 6;             // bit index into a coefficient

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_MUL  = 2'd2
	} mode_t;

	typedef enum logic {
		CMD_ADD = 1'b0,
		CMD_MUL = 1'b1
	} cmd_t;

	typedef struct packed {
		logic            command;
		logic [IDX_W-1:0] tower_index;
		logic [CW-1:0]   first_a;
		logic [CW-1:0]   second_a;
		logic [CW-1:0]   first_b;
		logic [CW-1:0]   second_b;
		logic            last_element;
	} in_t;

	typedef struct packed {
		logic [CW-1:0] first_result;
		logic [CW-1:0] second_result;
		logic          last;
	} out_t;

	// Working state of one lane as it moves down the pipeline.
	typedef struct packed {
		mode_t         mode;
		logic [AW-1:0] acc;  // add/pass result, or the running product
		logic [AW-1:0] ar;   // operand a reduced modulo q
		logic [CW-1:0] a;
		logic [CW-1:0] b;
		logic [CW-1:0] q;
	} lane_t;

	// Work done by pipeline stage k. The first CW stages reduce a modulo q, one
	// bit each (stage 0 also reduces an add's sum); the rest run an MSB-first
	// interleaved modular multiply, a doubling stage and an add stage per bit of b.
	function automatic lane_t rpmo_step(lane_t s, int k);
		lane_t         nx;
		logic [AW-1:0] q64;
		logic [AW-1:0] t;
		int            m;
		int            i;
		nx  = s;
		q64 = {{(AW-CW){1'b0}}, s.q};
		t   = '0;
		m   = 0;
		i   = 0;
		if (k < RED_STEPS) begin
			if (s.mode == MODE_MUL) begin
				t = {s.ar[AW-2:0], s.a[BIT_W'(CW - 1 - k)]};
				nx.ar = (t >= q64) ? (t - q64) : t;
			end
			if ((k == 0) && (s.mode == MODE_ADD)) begin
				t = (s.acc >= q64) ? (s.acc - q64) : s.acc;
				nx.acc = {{(AW-CW){1'b0}}, t[CW-1:0]};
			end
		end else begin
			m = k - RED_STEPS;
			i = CW - 1 - (m >> 1);
			if (s.mode == MODE_MUL) begin
				if ((m & 1) == 0) begin
					t = {s.acc[AW-2:0], 1'b0};
					nx.acc = (t >= q64) ? (t - q64) : t;
				end else if (s.b[BIT_W'(i)]) begin
					t = s.acc + s.ar;
					nx.acc = (t >= q64) ? (t - q64) : t;
				end
			end
		end
		return nx;
	endfunction

endpackage
`default_nettype wire

### rtl/rpmo_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpmo_lane
// One arithmetic lane: a fixed-depth pipeline that applies one step of the
// modular add or multiply per stage.
// ----------------------------------------------------------------------------
module rpmo_lane (
	input  wire logic              clk,
	input  wire rpmo_pkg::lane_t   lane_in,
	output rpmo_pkg::lane_t        lane_out
);
	import rpmo_pkg::*;

	lane_t stg_s [0:STEPS];

	always_ff @(posedge clk) begin
		stg_s[0] <= lane_in;
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		always_ff @(posedge clk) begin
			stg_s[k+1] <= rpmo_step(stg_s[k], k);
		end
	end

	assign lane_out = stg_s[STEPS];

endmodule
`default_nettype wire

### rtl/rpmo_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpmo_merge
// Output stage: combines the two lane results and the last flag into one
// registered result with its strobe.
// ----------------------------------------------------------------------------
module rpmo_merge (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld,
	input  wire logic              lst,
	input  wire rpmo_pkg::lane_t   lane_first,
	input  wire rpmo_pkg::lane_t   lane_second,
	output logic                   res_valid,
	output rpmo_pkg::out_t         rsp
);
	import rpmo_pkg::*;

	out_t rsp_q;
	logic res_valid_q;

	// A multiply by a zero modulus yields zero.
	function automatic logic [CW-1:0] lane_value(lane_t l);
		logic [CW-1:0] v;
		v = l.acc[CW-1:0];
		if ((l.mode == MODE_MUL) && (l.q == '0)) begin
			v = '0;
		end
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.first_result  <= lane_value(lane_first);
		rsp_q.second_result <= lane_value(lane_second);
		rsp_q.last          <= lst;
	end

	assign res_valid = res_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

### rtl/rns_pointwise_modular_ops_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rns_pointwise_modular_ops_core
// Pointwise modular add or multiply of one ciphertext coefficient pair per
// request, modulo the selected tower's RNS modulus; absent towers pass a through.
// ----------------------------------------------------------------------------
// A request is taken in every clock cycle (busy stays low) and its result
// appears on rsp with res_valid, one result per request, in order. Each
// request passes through the input register, the two lane pipelines (62
// stages reduce the multiplicand modulo q one bit at a time, 124 stages
// perform the interleaved modular multiply) and the output register. Adds
// take the same path so results never reorder. Results cannot be stalled.
// Moduli are written through the cfg port, which is always ready.
module rns_pointwise_modular_ops_core #(
	parameter int TOWERS = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire rpmo_pkg::in_t              req,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [rpmo_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [rpmo_pkg::CW-1:0]    cfg_data,
	output logic                            res_valid,
	output rpmo_pkg::out_t                  rsp
);
	import rpmo_pkg::*;

	localparam int LATENCY = STEPS + 2;

	logic [CW-1:0] modulus_q [0:MOD_REGS-1];
	logic          vld_s [0:STEPS];
	logic          lst_s [0:STEPS];
	lane_t         first_in;
	lane_t         second_in;
	lane_t         first_out;
	lane_t         second_out;
	logic          present;
	logic          accept;
	mode_t         mode;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MOD_REGS; r++) begin
				modulus_q[r] <= CW'(2);
			end
		end else if (cfg_valid && cfg_ready) begin
			modulus_q[cfg_index] <= cfg_data;
		end
	end

	assign present = (32'(req.tower_index) < TOWERS);

	always_comb begin
		if (!present) begin
			mode = MODE_PASS;
		end else if (cmd_t'(req.command) == CMD_MUL) begin
			mode = MODE_MUL;
		end else begin
			mode = MODE_ADD;
		end
	end

	function automatic lane_t lane_entry(mode_t md, logic [CW-1:0] a, logic [CW-1:0] b,
		logic [CW-1:0] q);
		lane_t l;
		l.mode = md;
		l.a    = a;
		l.b    = b;
		l.q    = q;
		l.ar   = '0;
		unique case (md)
			MODE_ADD: l.acc = AW'(a) + AW'(b);
			MODE_MUL: l.acc = '0;
			default:  l.acc = AW'(a);
		endcase
		return l;
	endfunction

	assign first_in  = lane_entry(mode, req.first_a, req.first_b,
		modulus_q[req.tower_index]);
	assign second_in = lane_entry(mode, req.second_a,
		(mode == MODE_MUL) ? req.first_b : req.second_b, modulus_q[req.tower_index]);

	rpmo_lane u_lane_first (
		.clk      (clk),
		.lane_in  (first_in),
		.lane_out (first_out)
	);

	rpmo_lane u_lane_second (
		.clk      (clk),
		.lane_in  (second_in),
		.lane_out (second_out)
	);

	// Request tracking alongside the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= STEPS; s++) begin
				vld_s[s] <= 1'b0;
			end
		end else begin
			vld_s[0] <= accept;
			for (int s = 0; s < STEPS; s++) begin
				vld_s[s+1] <= vld_s[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		lst_s[0] <= req.last_element;
		for (int s = 0; s < STEPS; s++) begin
			lst_s[s+1] <= lst_s[s];
		end
	end

	rpmo_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld         (vld_s[STEPS]),
		.lst         (lst_s[STEPS]),
		.lane_first  (first_out),
		.lane_second (second_out),
		.res_valid   (res_valid),
		.rsp         (rsp)
	);

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY res_valid)
		else $error("request did not produce a result at the expected cycle");

	a_result_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(accept, LATENCY))
		else $error("result without a matching request");

	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (rsp.last == $past(req.last_element, LATENCY)))
		else $error("last flag does not match its request");
`endif

endmodule
`default_nettype wire
